// ===== sv/tcsm_pkg.sv =====
package tcsm_pkg;

  localparam int unsigned ConnectionsDef = 8;

  localparam logic [7:0] HdrOverheadRst = 8'd58;

  localparam logic [15:0] FlagSyn = 16'h0200;
  localparam logic [15:0] FlagFin = 16'h0100;
  localparam logic [15:0] FlagAck = 16'h1000;

  localparam logic [3:0] StUnused      = 4'd0;
  localparam logic [3:0] StClosed      = 4'd1;
  localparam logic [3:0] StListen      = 4'd2;
  localparam logic [3:0] StSynSent     = 4'd3;
  localparam logic [3:0] StSynRcvd     = 4'd4;
  localparam logic [3:0] StEstablished = 4'd5;
  localparam logic [3:0] StFinWait1    = 4'd6;
  localparam logic [3:0] StFinWait2    = 4'd7;
  localparam logic [3:0] StClosing     = 4'd8;
  localparam logic [3:0] StTimeWait    = 4'd9;
  localparam logic [3:0] StLastAck     = 4'd10;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNotOpen  = 2'd1;
  localparam logic [1:0] StatusShort    = 2'd2;

  localparam logic FuncSegment = 1'b0;
  localparam logic FuncLoad    = 1'b1;

  typedef struct packed {
    logic        func;
    logic [2:0]  conn;
    logic [15:0] flag_word;
    logic [31:0] seq_no;
    logic [31:0] ack_no;
    logic [31:0] src_addr;
    logic [15:0] seg_port;
    logic [10:0] frame_len;
    logic [3:0]  load_state;
  } item_t;

  typedef struct packed {
    logic [3:0]  state;
    logic [31:0] snd;
    logic [31:0] rcv;
    logic [31:0] addr;
    logic [15:0] port;
  } slot_t;

  typedef struct packed {
    logic        send_valid;
    logic [15:0] flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] addr;
    logic [15:0] port;
    logic        deliver;
    logic [10:0] plen;
    logic [1:0]  status;
    logic [3:0]  state;
    logic        last;
  } res_t;

endpackage

// ===== sv/tcsm_step.sv =====
module tcsm_step (
  input  tcsm_pkg::item_t item_i,
  input  logic            in_range_i,
  input  tcsm_pkg::slot_t slot_i,
  input  logic [7:0]      hdr_i,
  output tcsm_pkg::slot_t slot_o,
  output logic            we_o,
  output tcsm_pkg::res_t  res0_o,
  output tcsm_pkg::res_t  res1_o,
  output logic            two_o
);
  import tcsm_pkg::*;

  logic        syn, fin, ack;
  logic [11:0] clen;
  logic        clen_neg, clen_pos;
  logic [10:0] plen;
  logic [31:0] sq_inc;
  logic        dlv;
  logic [1:0]  status;
  logic        nsend;
  logic [15:0] f0, f1;
  logic [31:0] s0, k0, s1, k1;
  slot_t       nxt;

  assign syn      = item_i.flag_word[9];
  assign fin      = item_i.flag_word[8];
  assign ack      = item_i.flag_word[12];
  assign clen     = {1'b0, item_i.frame_len} - {4'd0, hdr_i};
  assign clen_neg = clen[11];
  assign clen_pos = !clen_neg && (clen != 12'd0);
  assign plen     = clen[10:0];
  assign sq_inc   = item_i.seq_no + 32'd1;

  always_comb begin
    nxt    = slot_i;
    dlv    = 1'b0;
    status = StatusOk;
    nsend  = 1'b0;
    two_o  = 1'b0;
    f0 = '0; s0 = '0; k0 = '0;
    f1 = '0; s1 = '0; k1 = '0;
    if (syn && !ack) begin
      if (slot_i.state == StListen || slot_i.state == StSynSent) begin
        nxt.addr  = item_i.src_addr;
        nxt.port  = item_i.seg_port;
        nxt.rcv   = sq_inc;
        nxt.state = StSynRcvd;
        f0 = FlagAck | FlagSyn; s0 = slot_i.snd; k0 = sq_inc;
        nsend = 1'b1;
      end
    end else if (syn && ack) begin
      if (slot_i.state == StSynSent) begin
        nxt.addr  = item_i.src_addr;
        nxt.port  = item_i.seg_port;
        nxt.rcv   = sq_inc;
        nxt.snd   = slot_i.snd + 32'd1;
        nxt.state = StEstablished;
        f0 = FlagAck; s0 = slot_i.snd + 32'd1; k0 = sq_inc;
        nsend = 1'b1;
      end
    end else if (fin) begin
      if (slot_i.state == StEstablished || slot_i.state == StFinWait1 ||
          slot_i.state == StFinWait2) begin
        nxt.rcv = slot_i.rcv + 32'd1;
        f0 = FlagAck; s0 = item_i.ack_no; k0 = sq_inc;
        nsend = 1'b1;
        if (slot_i.state == StEstablished) begin
          f1 = FlagFin; s1 = item_i.ack_no; k1 = sq_inc;
          two_o     = 1'b1;
          nxt.state = StLastAck;
        end else if (slot_i.state == StFinWait2) begin
          nxt.state = StTimeWait;
        end else begin
          nxt.state = StClosing;
        end
      end
    end else if (ack) begin
      unique case (slot_i.state)
        StSynRcvd:  nxt.state = StEstablished;
        StFinWait1: nxt.state = StFinWait2;
        StClosing:  nxt.state = StTimeWait;
        StLastAck:  nxt.state = StClosed;
        StEstablished: begin
          if (clen_pos && slot_i.rcv == item_i.seq_no) begin
            dlv     = 1'b1;
            nxt.rcv = slot_i.rcv + {21'd0, plen};
          end
          if (clen_neg) begin
            status = StatusShort;
          end else if (item_i.ack_no > slot_i.snd) begin
            nxt.snd = item_i.ack_no;
          end
        end
        default: ;
      endcase
    end else begin
      if (clen_pos && item_i.seq_no == slot_i.rcv) begin
        dlv     = 1'b1;
        nxt.rcv = item_i.seq_no + {21'd0, plen};
        f0 = FlagAck; s0 = item_i.ack_no; k0 = item_i.seq_no + {21'd0, plen};
        nsend = 1'b1;
      end
      if (clen_neg) status = StatusShort;
    end

    we_o   = 1'b0;
    slot_o = nxt;
    res0_o = '0;
    res1_o = '0;
    res0_o.last = 1'b1;
    if (!in_range_i) begin
      res0_o.status = StatusNotOpen;
      two_o = 1'b0;
    end else if (item_i.func == FuncLoad) begin
      we_o          = 1'b1;
      slot_o.state  = (item_i.load_state <= StLastAck) ? item_i.load_state : StUnused;
      slot_o.snd    = item_i.seq_no;
      slot_o.rcv    = item_i.ack_no;
      slot_o.addr   = item_i.src_addr;
      slot_o.port   = item_i.seg_port;
      res0_o.addr   = item_i.src_addr;
      res0_o.port   = item_i.seg_port;
      res0_o.state  = slot_o.state;
      two_o = 1'b0;
    end else if (slot_i.state == StUnused) begin
      res0_o.status = StatusNotOpen;
      two_o = 1'b0;
    end else begin
      we_o = 1'b1;
      res0_o.send_valid = nsend;
      res0_o.flags      = f0;
      res0_o.seq        = s0;
      res0_o.ack        = k0;
      res0_o.addr       = nxt.addr;
      res0_o.port       = nxt.port;
      res0_o.deliver    = dlv;
      res0_o.plen       = dlv ? plen : 11'd0;
      res0_o.status     = status;
      res0_o.state      = nxt.state;
      res0_o.last       = !two_o;
      res1_o            = res0_o;
      res1_o.flags      = f1;
      res1_o.seq        = s1;
      res1_o.ack        = k1;
      res1_o.last       = 1'b1;
    end
  end

endmodule

// ===== sv/tcp_connection_state_machine.sv =====
// TCP connection handshake/teardown engine over CONNECTIONS slots.
// Input channel (in_valid_i/in_stall_o): one word per item, either a slot
// load (func_i = 1) or a received segment (func_i = 0). Output channel
// (out_valid_o/out_stall_i): one or two result words per item, last_o set on
// the final one. cfg_we_i/cfg_wdata_i write header_overhead; the user must do
// so only while idle, as the block does not enforce it. The item is registered
// on accept and its results into the result buffer when the step stage fires.
// Throughput: 1 item per cycle for single-result items without output stalls;
// the two-entry result buffer holds the step stage until it has room.
// Slot storage is a memory read on accept with a registered read; a slot
// written in the cycle it is read is forwarded. Per-slot valid flops make
// every slot read as unused/zero right after reset, so there is no clearing
// pass. Reset also sets header_overhead to 58 and empties the pipeline.
// A stalled receiver holds the current result; while the buffer holds an untaken
// word the step stage cannot fire and the input stalls as well, with no word lost.
module tcp_connection_state_machine #(
  parameter int unsigned CONNECTIONS = tcsm_pkg::ConnectionsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [2:0]  conn_i,
  input  logic [15:0] flag_word_i,
  input  logic [31:0] seq_no_i,
  input  logic [31:0] ack_no_i,
  input  logic [31:0] src_addr_i,
  input  logic [15:0] seg_port_i,
  input  logic [10:0] frame_len_i,
  input  logic [3:0]  load_state_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_valid_o,
  output logic [15:0] out_flags_o,
  output logic [31:0] out_seq_o,
  output logic [31:0] out_ack_o,
  output logic [31:0] peer_addr_out_o,
  output logic [15:0] peer_port_out_o,
  output logic        deliver_o,
  output logic [10:0] payload_len_o,
  output logic [1:0]  status_o,
  output logic [3:0]  new_state_o,
  output logic        last_o
);
  import tcsm_pkg::*;

  localparam int unsigned IdxW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

  logic [7:0]      hdr_q;
  slot_t           mem_q [CONNECTIONS];
  logic [CONNECTIONS-1:0] slot_vld_q;

  item_t           item_q;
  logic            in_vld_q;
  logic            in_range_q;
  logic [IdxW-1:0] addr_q;
  slot_t           rd_data_q;
  slot_t           fwd_slot_q;
  logic            fwd_q;
  logic            rd_vld_q;

  res_t            res_q [2];
  logic [1:0]      out_cnt_q;

  logic            accept, fire, out_take;
  logic [IdxW-1:0] rd_addr;
  logic            rd_range;
  logic            same_slot;
  slot_t           cur_slot, wr_slot;
  logic            we;
  res_t            r0, r1;
  logic            two;

  assign rd_addr  = IdxW'(conn_i);
  assign rd_range = {29'd0, conn_i} < 32'(CONNECTIONS);
  assign out_take = out_valid_o && !out_stall_i;
  assign fire     = in_vld_q && ((out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && out_take));
  assign in_stall_o = in_vld_q && !fire;
  assign accept   = in_valid_i && !in_stall_o;
  assign same_slot = fire && we && (addr_q == rd_addr);

  always_comb begin
    if (!rd_vld_q) begin
      cur_slot = '0;
    end else if (fwd_q) begin
      cur_slot = fwd_slot_q;
    end else begin
      cur_slot = rd_data_q;
    end
  end

  tcsm_step u_step (
    .item_i     (item_q),
    .in_range_i (in_range_q),
    .slot_i     (cur_slot),
    .hdr_i      (hdr_q),
    .slot_o     (wr_slot),
    .we_o       (we),
    .res0_o     (r0),
    .res1_o     (r1),
    .two_o      (two)
  );

  always_ff @(posedge clk_i) begin
    if (fire && we) mem_q[addr_q] <= wr_slot;
    if (accept) begin
      rd_data_q  <= mem_q[rd_addr];
      fwd_slot_q <= wr_slot;
      item_q     <= '{func: func_i, conn: conn_i, flag_word: flag_word_i,
                      seq_no: seq_no_i, ack_no: ack_no_i, src_addr: src_addr_i,
                      seg_port: seg_port_i, frame_len: frame_len_i,
                      load_state: load_state_i};
      addr_q     <= rd_addr;
      in_range_q <= rd_range;
    end
    if (fire) begin
      res_q[0] <= r0;
      res_q[1] <= r1;
    end else if (out_take && out_cnt_q == 2'd2) begin
      res_q[0] <= res_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q      <= HdrOverheadRst;
      slot_vld_q <= '0;
      in_vld_q   <= 1'b0;
      fwd_q      <= 1'b0;
      rd_vld_q   <= 1'b0;
      out_cnt_q  <= 2'd0;
    end else begin
      if (cfg_we_i) hdr_q <= cfg_wdata_i;
      if (fire && we) slot_vld_q[addr_q] <= 1'b1;
      if (accept) begin
        in_vld_q <= 1'b1;
        fwd_q    <= same_slot;
        rd_vld_q <= slot_vld_q[rd_addr] || same_slot;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_cnt_q <= two ? 2'd2 : 2'd1;
      end else if (out_take) begin
        out_cnt_q <= out_cnt_q - 2'd1;
      end
    end
  end

  assign out_valid_o     = out_cnt_q != 2'd0;
  assign send_valid_o    = res_q[0].send_valid;
  assign out_flags_o     = res_q[0].flags;
  assign out_seq_o       = res_q[0].seq;
  assign out_ack_o       = res_q[0].ack;
  assign peer_addr_out_o = res_q[0].addr;
  assign peer_port_out_o = res_q[0].port;
  assign deliver_o       = res_q[0].deliver;
  assign payload_len_o   = res_q[0].plen;
  assign status_o        = res_q[0].status;
  assign new_state_o     = res_q[0].state;
  assign last_o          = res_q[0].last;

endmodule

// ===== sv/tcsm_checker.sv =====
module tcsm_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        send_valid_o,
  input logic [15:0] out_flags_o,
  input logic [31:0] out_seq_o,
  input logic [31:0] out_ack_o,
  input logic        deliver_o,
  input logic [10:0] payload_len_o,
  input logic [1:0]  status_o,
  input logic        last_o
);
  import tcsm_pkg::*;

  // a held word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // second reply is already buffered behind the first
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && send_valid_o)
    else $error("second reply word not ready");

  a_nosend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_valid_o |->
      out_flags_o == 16'd0 && out_seq_o == 32'd0 && out_ack_o == 32'd0 && last_o)
    else $error("segment fields set without send");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |-> !deliver_o && !send_valid_o)
    else $error("error status with delivery or reply");

  a_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !deliver_o |-> payload_len_o == 11'd0)
    else $error("payload length without delivery");

endmodule

bind tcp_connection_state_machine tcsm_assert u_tcsm_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .send_valid_o  (send_valid_o),
  .out_flags_o   (out_flags_o),
  .out_seq_o     (out_seq_o),
  .out_ack_o     (out_ack_o),
  .deliver_o     (deliver_o),
  .payload_len_o (payload_len_o),
  .status_o      (status_o),
  .last_o        (last_o)
);

// ===== tb/tcsm_checker.sv =====
`timescale 1ns / 100ps

module tcsm_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  tcsm_pkg::item_t word_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  tcsm_pkg::res_t  res_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              results_o,
  output int              deliveries_o
);
  import tcsm_pkg::*;

  logic [7:0] hdr_bytes;
  slot_t      slot_tab [ConnectionsDef];
  res_t       expected_replies [$];

  function automatic void predict_replies(input item_t w);
    slot_t       s;
    res_t        r;
    logic        syn, fin, ack, dlv;
    logic [15:0] fl [2];
    logic [31:0] sq [2];
    logic [31:0] ak [2];
    logic [10:0] plen;
    logic [1:0]  stat;
    logic [3:0]  st;
    int          nsend;
    int          clen;
    s = slot_tab[w.conn];
    r = '0;
    if (w.func == FuncLoad) begin
      s.state = (w.load_state <= StLastAck) ? w.load_state : StUnused;
      s.snd = w.seq_no;
      s.rcv = w.ack_no;
      s.addr = w.src_addr;
      s.port = w.seg_port;
      slot_tab[w.conn] = s;
      r.addr = s.addr;
      r.port = s.port;
      r.status = StatusOk;
      r.state = s.state;
      r.last = 1'b1;
      expected_replies.push_back(r);
      return;
    end
    if (s.state == StUnused) begin
      r.status = StatusNotOpen;
      r.last = 1'b1;
      expected_replies.push_back(r);
      return;
    end
    syn = (w.flag_word & FlagSyn) != 0;
    fin = (w.flag_word & FlagFin) != 0;
    ack = (w.flag_word & FlagAck) != 0;
    clen = int'(w.frame_len) - int'(hdr_bytes);
    dlv = 1'b0;
    plen = '0;
    stat = StatusOk;
    st = s.state;
    nsend = 0;
    fl[0] = '0; fl[1] = '0;
    sq[0] = '0; sq[1] = '0;
    ak[0] = '0; ak[1] = '0;
    if (syn && !ack) begin
      if (st == StListen || st == StSynSent) begin
        s.addr = w.src_addr;
        s.port = w.seg_port;
        s.rcv = w.seq_no + 32'd1;
        fl[0] = FlagAck | FlagSyn; sq[0] = s.snd; ak[0] = s.rcv;
        nsend = 1;
        st = StSynRcvd;
      end
    end else if (syn && ack) begin
      if (st == StSynSent) begin
        s.addr = w.src_addr;
        s.port = w.seg_port;
        s.rcv = w.seq_no + 32'd1;
        s.snd = s.snd + 32'd1;
        fl[0] = FlagAck; sq[0] = s.snd; ak[0] = s.rcv;
        nsend = 1;
        st = StEstablished;
      end
    end else if (fin) begin
      if (st == StEstablished || st == StFinWait2 || st == StFinWait1) begin
        s.rcv = s.rcv + 32'd1;
        fl[0] = FlagAck; sq[0] = w.ack_no; ak[0] = w.seq_no + 32'd1;
        nsend = 1;
        if (st == StEstablished) begin
          fl[1] = FlagFin; sq[1] = w.ack_no; ak[1] = w.seq_no + 32'd1;
          nsend = 2;
          st = StLastAck;
        end else if (st == StFinWait2) begin
          st = StTimeWait;
        end else begin
          st = StClosing;
        end
      end
    end else if (ack) begin
      case (st)
        StSynRcvd:  st = StEstablished;
        StFinWait1: st = StFinWait2;
        StClosing:  st = StTimeWait;
        StLastAck:  st = StClosed;
        StEstablished: begin
          if (clen > 0 && s.rcv == w.seq_no) begin
            dlv = 1'b1;
            plen = clen[10:0];
            s.rcv = s.rcv + 32'(plen);
          end
          if (clen < 0) stat = StatusShort;
          else if (w.ack_no > s.snd) s.snd = w.ack_no;
        end
        default: ;
      endcase
    end else begin
      if (clen > 0 && w.seq_no == s.rcv) begin
        dlv = 1'b1;
        plen = clen[10:0];
        s.rcv = w.seq_no + 32'(plen);
        fl[0] = FlagAck; sq[0] = w.ack_no; ak[0] = s.rcv;
        nsend = 1;
      end
      if (clen < 0) stat = StatusShort;
    end
    s.state = st;
    slot_tab[w.conn] = s;
    r.addr = s.addr;
    r.port = s.port;
    r.deliver = dlv;
    r.plen = plen;
    r.status = stat;
    r.state = st;
    if (nsend == 0) begin
      r.last = 1'b1;
      expected_replies.push_back(r);
    end else begin
      for (int k = 0; k < nsend; k++) begin
        r.send_valid = 1'b1;
        r.flags = fl[k];
        r.seq = sq[k];
        r.ack = ak[k];
        r.last = (k == nsend - 1);
        expected_replies.push_back(r);
      end
    end
  endfunction

  function automatic int field_diff(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    int   bad;
    if (!rst_ni) begin
      hdr_bytes = HdrOverheadRst;
      foreach (slot_tab[i]) slot_tab[i] = '0;
      expected_replies.delete();
      fail_count_o = 0;
      results_o = 0;
      deliveries_o = 0;
    end else begin
      if (cfg_we_i) hdr_bytes = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_replies(word_i);
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (res_i.deliver === 1'b1 && res_i.last === 1'b1) deliveries_o++;
        if (expected_replies.size() == 0) begin
          $error("result word with nothing expected: %h", res_i);
          fail_count_o++;
        end else begin
          want = expected_replies.pop_front();
          bad = 0;
          bad += field_diff("send_valid", 32'(want.send_valid), 32'(res_i.send_valid));
          bad += field_diff("out_flags", 32'(want.flags), 32'(res_i.flags));
          bad += field_diff("out_seq", want.seq, res_i.seq);
          bad += field_diff("out_ack", want.ack, res_i.ack);
          bad += field_diff("peer_addr_out", want.addr, res_i.addr);
          bad += field_diff("peer_port_out", 32'(want.port), 32'(res_i.port));
          bad += field_diff("deliver", 32'(want.deliver), 32'(res_i.deliver));
          bad += field_diff("payload_len", 32'(want.plen), 32'(res_i.plen));
          bad += field_diff("status", 32'(want.status), 32'(res_i.status));
          bad += field_diff("new_state", 32'(want.state), 32'(res_i.state));
          bad += field_diff("last", 32'(want.last), 32'(res_i.last));
          if (bad != 0) fail_count_o++;
        end
      end
    end
    pending_o = expected_replies.size();
  end

endmodule

// ===== tb/tb_tcp_connection_state_machine.sv =====
`timescale 1ns / 100ps

module tb_tcp_connection_state_machine;
  import tcsm_pkg::*;

  localparam int HoldCycles = 80;
  localparam int HoldAt     = 400;
  localparam int CycleLimit = 300000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  item_t       word = '0;
  logic        out_stall = 1'b0;
  logic        in_stall, out_valid;
  logic        snd_valid, rsp_deliver, rsp_last;
  logic [15:0] rsp_flags, rsp_port;
  logic [31:0] rsp_seq, rsp_ack, rsp_addr;
  logic [10:0] rsp_plen;
  logic [1:0]  rsp_status;
  logic [3:0]  rsp_state;
  res_t        reply;

  int          fail_count, pending, n_results, n_deliver;
  int          n_words = 0;
  int          n_loads = 0;
  int          cycles = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;
  logic [7:0]  hdr_now = HdrOverheadRst;
  logic [31:0] peer_next = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign reply = {snd_valid, rsp_flags, rsp_seq, rsp_ack, rsp_addr, rsp_port,
                  rsp_deliver, rsp_plen, rsp_status, rsp_state, rsp_last};

  tcp_connection_state_machine u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .func_i          (word.func),
    .conn_i          (word.conn),
    .flag_word_i     (word.flag_word),
    .seq_no_i        (word.seq_no),
    .ack_no_i        (word.ack_no),
    .src_addr_i      (word.src_addr),
    .seg_port_i      (word.seg_port),
    .frame_len_i     (word.frame_len),
    .load_state_i    (word.load_state),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .send_valid_o    (snd_valid),
    .out_flags_o     (rsp_flags),
    .out_seq_o       (rsp_seq),
    .out_ack_o       (rsp_ack),
    .peer_addr_out_o (rsp_addr),
    .peer_port_out_o (rsp_port),
    .deliver_o       (rsp_deliver),
    .payload_len_o   (rsp_plen),
    .status_o        (rsp_status),
    .new_state_o     (rsp_state),
    .last_o          (rsp_last)
  );

  tcsm_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .word_i       (word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .res_i        (reply),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (n_results),
    .deliveries_o (n_deliver)
  );

  function automatic logic quiet();
    return n_words >= 700 && n_words < 1000;
  endfunction

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet() && ($urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive(input item_t w);
    if (!quiet() && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    word <= w;
    do @(posedge clk); while (in_stall);
    n_words++;
    if (w.func == FuncLoad) n_loads++;
    if (n_words == HoldAt) hold_req = 1'b1;
    @(negedge clk);
  endtask

  task automatic put_cfg(input logic [7:0] v);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    hdr_now = v;
  endtask

  function automatic logic [15:0] flags_with(input logic [15:0] set);
    return (16'($urandom) & ~(FlagSyn | FlagFin | FlagAck)) | set;
  endfunction

  function automatic logic [31:0] pick_seq();
    case ($urandom_range(0, 7))
      0:       return 32'hFFFF_FFFF - $urandom_range(0, 3000);
      1:       return $urandom_range(0, 3000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [10:0] pick_len();
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 2047;
      2, 3:    v = int'(hdr_now) + int'($urandom_range(0, 4)) - 2;
      default: v = int'($urandom_range(0, 2047));
    endcase
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return v[10:0];
  endfunction

  function automatic item_t mk_seg(input logic [2:0] c, input logic [15:0] fl,
                                   input logic [31:0] sq, input logic [31:0] ak,
                                   input logic [10:0] len);
    item_t w;
    w.func = FuncSegment;
    w.conn = c;
    w.flag_word = fl;
    w.seq_no = sq;
    w.ack_no = ak;
    w.src_addr = $urandom;
    w.seg_port = 16'($urandom);
    w.frame_len = len;
    w.load_state = 4'($urandom_range(0, 15));
    return w;
  endfunction

  function automatic item_t mk_load(input logic [2:0] c, input logic [3:0] ls,
                                    input logic [31:0] snd, input logic [31:0] rcv);
    item_t w;
    w = mk_seg(c, 16'($urandom), snd, rcv, 11'($urandom_range(0, 2047)));
    w.func = FuncLoad;
    w.load_state = ls;
    return w;
  endfunction

  function automatic item_t mk_noise();
    item_t w;
    w = mk_seg(3'($urandom_range(0, 7)), 16'($urandom), $urandom, $urandom,
               11'($urandom_range(0, 2047)));
    w.func = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic send_data(input logic [2:0] c, input logic with_ack,
                           input logic in_order, input logic [10:0] len);
    logic [31:0] sq;
    int          clen;
    sq = in_order ? peer_next : peer_next + 32'd1 + $urandom_range(0, 100000);
    clen = int'(len) - int'(hdr_now);
    drive(mk_seg(c, flags_with(with_ack ? FlagAck : 16'h0000), sq, $urandom, len));
    if (in_order && clen > 0) peer_next = peer_next + 32'(clen);
  endtask

  task automatic chat(input logic [2:0] c, input int n);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0)
        drive(mk_seg(c, flags_with(FlagSyn | ($urandom_range(0, 1) ? FlagAck : 16'h0)),
                     $urandom, $urandom, pick_len()));
      else
        send_data(c, $urandom_range(0, 3) != 0, $urandom_range(0, 9) != 0, pick_len());
    end
  endtask

  task automatic fin_word(input logic [2:0] c);
    drive(mk_seg(c, flags_with(FlagFin | ($urandom_range(0, 1) ? FlagAck : 16'h0)),
                 peer_next, $urandom, pick_len()));
  endtask

  task automatic ack_word(input logic [2:0] c);
    drive(mk_seg(c, flags_with(FlagAck), $urandom, $urandom, pick_len()));
  endtask

  // one connection's life, well-formed with random content
  task automatic talk(input logic [2:0] c);
    logic [31:0] sq;
    peer_next = pick_seq();
    sq = pick_seq();
    case ($urandom_range(0, 3))
      0: begin
        drive(mk_load(c, StListen, pick_seq(), peer_next));
        drive(mk_seg(c, flags_with(FlagSyn), sq, $urandom, pick_len()));
        peer_next = sq + 32'd1;
        ack_word(c);
        chat(c, $urandom_range(1, 8));
        fin_word(c);
        ack_word(c);
      end
      1: begin
        drive(mk_load(c, StSynSent, pick_seq(), peer_next));
        drive(mk_seg(c, flags_with(FlagSyn | FlagAck), sq, $urandom, pick_len()));
        peer_next = sq + 32'd1;
        chat(c, $urandom_range(1, 8));
        drive(mk_load(c, StFinWait1, pick_seq(), peer_next));
        if ($urandom_range(0, 1)) begin
          ack_word(c);
          fin_word(c);
        end else begin
          fin_word(c);
          ack_word(c);
        end
      end
      2: begin
        drive(mk_load(c, StSynSent, pick_seq(), peer_next));
        drive(mk_seg(c, flags_with(FlagSyn), sq, $urandom, pick_len()));
        peer_next = sq + 32'd1;
        ack_word(c);
        chat(c, $urandom_range(1, 6));
        fin_word(c);
        ack_word(c);
      end
      default: begin
        drive(mk_load(c, StEstablished, pick_seq(), peer_next));
        chat(c, $urandom_range(4, 14));
      end
    endcase
  endtask

  initial begin
    item_t w;
    int    target;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: unused slot, bad load code, full handshake and teardown
    drive(mk_seg(3'd0, 16'h0000, '1, '1, 11'd2047));
    w = mk_load(3'd0, 4'd15, '0, '0);
    w.src_addr = '0;
    w.seg_port = '0;
    drive(w);
    drive(mk_seg(3'd0, FlagSyn, '0, '0, 11'd0));
    w = mk_load(3'd1, StListen, '1, '0);
    w.src_addr = '1;
    w.seg_port = '1;
    w.flag_word = '1;
    w.frame_len = '1;
    drive(w);
    drive(mk_seg(3'd1, FlagSyn, '1, '0, 11'd0));
    peer_next = '0;
    drive(mk_seg(3'd1, FlagSyn, $urandom, $urandom, 11'd100));
    drive(mk_seg(3'd1, FlagFin, $urandom, $urandom, 11'd100));
    drive(mk_seg(3'd1, FlagAck, $urandom, '1, 11'd100));
    send_data(3'd1, 1'b1, 1'b1, 11'd2047);
    send_data(3'd1, 1'b1, 1'b1, 11'd0);
    send_data(3'd1, 1'b0, 1'b1, 11'd58);
    send_data(3'd1, 1'b0, 1'b1, 11'd1000);
    send_data(3'd1, 1'b0, 1'b0, 11'd500);
    send_data(3'd1, 1'b0, 1'b1, 11'd10);
    drive(mk_seg(3'd1, 16'hFFFF, $urandom, $urandom, 11'd300));
    drive(mk_seg(3'd1, FlagFin | FlagAck, peer_next, '1, 11'd60));
    drive(mk_seg(3'd1, FlagAck, $urandom, $urandom, 11'd60));
    drive(mk_seg(3'd1, 16'h0000, $urandom, $urandom, 11'd2047));
    drive(mk_load(3'd7, StSynSent, '1, '1));
    drive(mk_seg(3'd7, FlagSyn | FlagAck, '1, '1, 11'd58));
    drive(mk_load(3'd2, StFinWait1, $urandom, $urandom));
    drive(mk_seg(3'd2, FlagFin, $urandom, $urandom, 11'd58));
    drive(mk_seg(3'd2, FlagAck, $urandom, $urandom, 11'd58));
    drive(mk_load(3'd3, StFinWait2, $urandom, $urandom));
    drive(mk_seg(3'd3, FlagFin | FlagAck, $urandom, $urandom, 11'd58));
    drive(mk_load(3'd4, StFinWait1, $urandom, $urandom));
    drive(mk_seg(3'd4, FlagAck, $urandom, $urandom, 11'd58));

    // random: six header-overhead settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        1:       put_cfg(8'd0);
        2:       put_cfg(8'd255);
        3:       put_cfg(8'd20);
        4, 5:    put_cfg(8'($urandom_range(1, 254)));
        default: ;
      endcase
      target = 28 + (p + 1) * 287;
      while (n_words < target) begin
        if ($urandom_range(0, 3) != 0) talk(3'($urandom_range(0, 7)));
        else drive(mk_noise());
      end
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    $display("Covered %0d words (%0d slot loads) across six header-overhead settings,",
             n_words, n_loads);
    $display("with %0d result words checked and %0d in-order payload deliveries.",
             n_results, n_deliver);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tcsm_pkg.sv
sv/tcsm_step.sv
sv/tcp_connection_state_machine.sv
sv/tcsm_checker.sv
tb/tcsm_checker.sv
tb/tb_tcp_connection_state_machine.sv
